// ===== src/roim_pkg.sv =====
// Shared types and constants for the row order index manager.
// Used by roim_ctrl, roim_dp and row_order_index_manager_core; no dependencies.
package roim_pkg;

  localparam int MAX_ROWS = 256;
  localparam int SLOT_W   = $clog2(MAX_ROWS);
  localparam int COUNT_W  = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SWAP   = 2'd2,
    KIND_INSERT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] first_row;
    logic [SLOT_W-1:0] second_row;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  new_position;
    logic               move_needed;
    logic [SLOT_W-1:0]  move_source;
    logic [SLOT_W-1:0]  move_target;
    logic [COUNT_W-1:0] rows_now;
  } rsp_t;

  // One datapath operation per cycle.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_APPEND,
    DP_SET_FULL,
    DP_SET_OOB,
    DP_RM_RD,
    DP_RM_CHECK,
    DP_SEARCH,
    DP_MOVE,
    DP_DN_INIT,
    DP_DN_RD,
    DP_UP_RD,
    DP_PUT,
    DP_RD_R1,
    DP_RD_R2,
    DP_SW_W1,
    DP_SW_W2,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;     // table holds MAX_ROWS rows
    logic  r1_oob;   // first_row >= row count
    logic  r2_oob;   // second_row >= row count
    logic  hit;      // read data equals row count
    logic  dn_last;  // down stream reads its final address
    logic  up_last;  // up stream reads its final address
  } dp_stat_t;

endpackage

// ===== src/roim_ctrl.sv =====
// Sequencer for the row order index manager: one datapath op per cycle.
// Depends on roim_pkg.
module roim_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  roim_pkg::dp_stat_t stat,
  output roim_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RUN,
    S_INS_DRAIN,
    S_INS_PUT,
    S_RM_CHECK,
    S_RM_SEARCH,
    S_DN_INIT,
    S_DN_RUN,
    S_DN_DRAIN,
    S_SW_RD2,
    S_SW_W1,
    S_SW_W2,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = roim_pkg::DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = roim_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.kind) inside
          roim_pkg::KIND_APPEND, roim_pkg::KIND_INSERT: begin
            if (stat.full) begin
              cmd.op     = roim_pkg::DP_SET_FULL;
              state_next = S_EMIT;
            end else begin
              cmd.op = roim_pkg::DP_APPEND;
              // insert at or past the end is a plain append
              if (stat.kind == roim_pkg::KIND_INSERT && !stat.r1_oob) begin
                state_next = S_INS_RUN;
              end else begin
                state_next = S_EMIT;
              end
            end
          end
          roim_pkg::KIND_REMOVE: begin
            if (stat.r1_oob) begin
              cmd.op     = roim_pkg::DP_SET_OOB;
              state_next = S_EMIT;
            end else begin
              cmd.op     = roim_pkg::DP_RM_RD;
              state_next = S_RM_CHECK;
            end
          end
          roim_pkg::KIND_SWAP: begin
            if (stat.r1_oob || stat.r2_oob) begin
              cmd.op     = roim_pkg::DP_SET_OOB;
              state_next = S_EMIT;
            end else begin
              cmd.op     = roim_pkg::DP_RD_R1;
              state_next = S_SW_RD2;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_INS_RUN: begin
        cmd.op = roim_pkg::DP_UP_RD;
        if (stat.up_last) begin
          state_next = S_INS_DRAIN;
        end
      end
      S_INS_DRAIN: state_next = S_INS_PUT;
      S_INS_PUT: begin
        cmd.op     = roim_pkg::DP_PUT;
        state_next = S_EMIT;
      end
      S_RM_CHECK: begin
        cmd.op     = roim_pkg::DP_RM_CHECK;
        // removed row already sits in the last slot: no data move
        state_next = stat.hit ? S_DN_INIT : S_RM_SEARCH;
      end
      S_RM_SEARCH: begin
        if (stat.hit) begin
          cmd.op     = roim_pkg::DP_MOVE;
          state_next = S_DN_INIT;
        end else begin
          cmd.op = roim_pkg::DP_SEARCH;
        end
      end
      S_DN_INIT: begin
        if (stat.r1_oob) begin
          state_next = S_EMIT;
        end else begin
          cmd.op     = roim_pkg::DP_DN_INIT;
          state_next = S_DN_RUN;
        end
      end
      S_DN_RUN: begin
        cmd.op = roim_pkg::DP_DN_RD;
        if (stat.dn_last) begin
          state_next = S_DN_DRAIN;
        end
      end
      S_DN_DRAIN: state_next = S_EMIT;
      S_SW_RD2: begin
        cmd.op     = roim_pkg::DP_RD_R2;
        state_next = S_SW_W1;
      end
      S_SW_W1: begin
        cmd.op     = roim_pkg::DP_SW_W1;
        state_next = S_SW_W2;
      end
      S_SW_W2: begin
        cmd.op     = roim_pkg::DP_SW_W2;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.op     = roim_pkg::DP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_emit_frees: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == roim_pkg::DP_EMIT) |=> !busy)
    else $error("busy held after result emitted");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with sequencer state");
`endif

endmodule

// ===== src/roim_dp.sv =====
// Datapath for the row order index manager: position map memory,
// row count, address pointer and result registers. Depends on roim_pkg.
module roim_dp (
  input  logic               clk,
  input  logic               rst,
  input  roim_pkg::req_t     request,
  input  roim_pkg::dp_cmd_t  cmd,
  output roim_pkg::dp_stat_t stat,
  output roim_pkg::rsp_t     result,
  output logic               done
);

  logic [roim_pkg::SLOT_W-1:0]  mem [roim_pkg::MAX_ROWS];

  roim_pkg::kind_t              kind_q;
  logic [roim_pkg::SLOT_W-1:0]  r1;
  logic [roim_pkg::SLOT_W-1:0]  r2;
  logic [roim_pkg::COUNT_W-1:0] total;
  logic [roim_pkg::SLOT_W-1:0]  ptr;
  logic [roim_pkg::SLOT_W-1:0]  raddr_q;
  logic [roim_pkg::SLOT_W-1:0]  rdata;
  logic [roim_pkg::SLOT_W-1:0]  hold;
  logic                         wb_up;
  logic                         wb_dn;

  roim_pkg::status_t            st;
  logic [roim_pkg::SLOT_W-1:0]  newpos;
  logic                         mv;
  logic [roim_pkg::SLOT_W-1:0]  src;
  logic [roim_pkg::SLOT_W-1:0]  dst;

  logic                         rd_en;
  logic [roim_pkg::SLOT_W-1:0]  rd_addr;
  logic                         we;
  logic [roim_pkg::SLOT_W-1:0]  wr_addr;
  logic [roim_pkg::SLOT_W-1:0]  wr_data;

  // Stream writeback lands in the cycle after its read.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    we      = 1'b0;
    wr_addr = raddr_q;
    wr_data = rdata;
    if (wb_up) begin
      we      = 1'b1;
      wr_addr = raddr_q + 1'b1;
    end else if (wb_dn) begin
      we      = 1'b1;
      wr_addr = raddr_q - 1'b1;
    end
    unique case (cmd.op) inside
      roim_pkg::DP_APPEND: begin
        we      = 1'b1;
        wr_addr = total[roim_pkg::SLOT_W-1:0];
        wr_data = total[roim_pkg::SLOT_W-1:0];
      end
      roim_pkg::DP_RM_RD, roim_pkg::DP_RD_R1: begin
        rd_en   = 1'b1;
        rd_addr = r1;
      end
      roim_pkg::DP_RM_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      roim_pkg::DP_SEARCH, roim_pkg::DP_UP_RD, roim_pkg::DP_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr;
      end
      roim_pkg::DP_RD_R2: begin
        rd_en   = 1'b1;
        rd_addr = r2;
      end
      roim_pkg::DP_MOVE: begin
        we      = 1'b1;
        wr_addr = raddr_q;
        wr_data = hold;
      end
      roim_pkg::DP_PUT: begin
        we      = 1'b1;
        wr_addr = r1;
        wr_data = hold;
      end
      roim_pkg::DP_SW_W1: begin
        we      = 1'b1;
        wr_addr = r1;
        wr_data = rdata;
      end
      roim_pkg::DP_SW_W2: begin
        we      = 1'b1;
        wr_addr = r2;
        wr_data = hold;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata   <= mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      wb_up <= 1'b0;
      wb_dn <= 1'b0;
      done  <= 1'b0;
    end else begin
      wb_up <= (cmd.op == roim_pkg::DP_UP_RD);
      wb_dn <= (cmd.op == roim_pkg::DP_DN_RD);
      done  <= (cmd.op == roim_pkg::DP_EMIT);
      if (cmd.op == roim_pkg::DP_APPEND) begin
        total <= total + 1'b1;
      end else if (cmd.op == roim_pkg::DP_RM_RD) begin
        total <= total - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      roim_pkg::DP_LOAD: begin
        kind_q <= request.kind;
        r1     <= request.first_row;
        r2     <= request.second_row;
        st     <= roim_pkg::STAT_OK;
        newpos <= '0;
        mv     <= 1'b0;
        src    <= '0;
        dst    <= '0;
      end
      roim_pkg::DP_APPEND: begin
        newpos <= total[roim_pkg::SLOT_W-1:0];
        hold   <= total[roim_pkg::SLOT_W-1:0];
        ptr    <= total[roim_pkg::SLOT_W-1:0] - 1'b1;
      end
      roim_pkg::DP_SET_FULL: st <= roim_pkg::STAT_FULL;
      roim_pkg::DP_SET_OOB:  st <= roim_pkg::STAT_RANGE;
      roim_pkg::DP_RM_CHECK: begin
        hold <= rdata;
        ptr  <= roim_pkg::SLOT_W'(1);
      end
      roim_pkg::DP_SEARCH: ptr <= ptr + 1'b1;
      roim_pkg::DP_DN_RD:  ptr <= ptr + 1'b1;
      roim_pkg::DP_UP_RD:  ptr <= ptr - 1'b1;
      roim_pkg::DP_MOVE: begin
        mv  <= 1'b1;
        src <= total[roim_pkg::SLOT_W-1:0];
        dst <= hold;
      end
      roim_pkg::DP_DN_INIT: ptr <= r1 + 1'b1;
      roim_pkg::DP_RD_R2:   hold <= rdata;
      roim_pkg::DP_PUT:     newpos <= r1;
      roim_pkg::DP_EMIT: begin
        result.status       <= st;
        result.new_position <= newpos;
        result.move_needed  <= mv;
        result.move_source  <= src;
        result.move_target  <= dst;
        result.rows_now     <= total;
      end
      default: ;
    endcase
  end

  assign stat.kind    = kind_q;
  assign stat.full    = (total == roim_pkg::COUNT_W'(roim_pkg::MAX_ROWS));
  assign stat.r1_oob  = (roim_pkg::COUNT_W'(r1) >= total);
  assign stat.r2_oob  = (roim_pkg::COUNT_W'(r2) >= total);
  assign stat.hit     = (roim_pkg::COUNT_W'(rdata) == total);
  assign stat.dn_last = (roim_pkg::COUNT_W'(ptr) == total);
  assign stat.up_last = (ptr == r1);

`ifndef SYNTHESIS
  a_wb_no_clash: assert property (@(posedge clk) disable iff (rst)
    (wb_up || wb_dn) |-> (cmd.op == roim_pkg::DP_NOP || cmd.op == roim_pkg::DP_UP_RD ||
                          cmd.op == roim_pkg::DP_DN_RD))
    else $error("map write port used twice in one cycle");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= roim_pkg::COUNT_W'(roim_pkg::MAX_ROWS))
    else $error("row count above table size");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== src/row_order_index_manager_core.sv =====
// Top level of the row order index manager: sequencer plus datapath.
// Depends on roim_pkg, roim_ctrl and roim_dp.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  request   | start in, busy out     | request (kind, first_row, second_row)
//  result    | done out (1-cycle)     | result (status .. rows_now)
//
// A request is taken at an edge with start high and busy low; busy stays
// high until the result is emitted. done is high for exactly one cycle.
// Insert at p shifts map entries p .. n-1 up by one, n = rows held before
// the request, then writes the new entry at p; remove finds the entry
// holding the last slot, gives it the removed row's slot, then shifts the
// entries above the removed row down. The position map (one read, one
// write per cycle) sets how long these walks take.
// Reset empties the table; the map holds no valid flags since only
// entries below the row count are ever read. The receiver cannot stall.
module row_order_index_manager_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  roim_pkg::req_t  request,
  output logic            done,
  output roim_pkg::rsp_t  result
);

  roim_pkg::dp_cmd_t  cmd;
  roim_pkg::dp_stat_t stat;

  // control: walks append / insert shift / remove search+shift / swap
  roim_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: map memory, row count, pointer, result registers
  roim_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule
